FILE: sv/hpl_pkg.sv
// hpl_pkg.sv: widths, register indexes, status codes and the item record
// shared by the heating pipe heat loss unit. No dependencies.
package hpl_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_INFLOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAT_COEFF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_VOL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_CNT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AREA       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEAT_CAP   = 3'd6;

  localparam logic signed [15:0] RST_MAX_INFLOW = 16'sd20480;
  localparam logic [23:0]        RST_HEAT_COEFF = 24'd128345;
  localparam logic [13:0]        RST_EXPONENT_B = 14'd5734;
  localparam logic [31:0]        RST_SPAN_VOL   = 32'd1000000;
  localparam logic [7:0]         RST_SPAN_CNT   = 8'd1;
  localparam logic [19:0]        RST_AREA       = 20'd1000;
  localparam logic [12:0]        RST_HEAT_CAP   = 13'd4184;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_FLOW = 2'd1;
  localparam logic [1:0] ST_SAT       = 2'd2;

  localparam logic [15:0] DEFAULT_FLOW = 16'd5000;
  localparam logic [13:0] B_MIN        = 14'd4097;
  localparam logic [13:0] B_ONE        = 14'd4096;
  localparam int          FLUX_SCALE   = 16000;

  localparam int QF = 32;

  localparam int LG_LANES = 4;
  localparam int LG_IN_W  = 64;
  localparam int LG_NORM  = 6;
  localparam int LG_W     = 38;

  localparam int DIV_NUM_W = 54;
  localparam int DIV_DEN_W = 36;

  localparam int          EXP_IN_W    = 52;
  localparam int          EXP_OUT_W   = 63;
  localparam int          EXP_SUM_W   = 34;
  localparam int          EXP_TERMS   = 30;
  localparam int          EXP_MAX_SHL = 29;
  localparam int          EXP_MIN_SHR = 34;
  localparam logic [31:0] LN2_Q32     = 32'hB17217F8;

  localparam int L_W = 40;

  typedef struct packed {
    logic                  zero_flow;
    logic                  cool;
    logic                  big;
    logic                  tiny;
    logic [15:0]           flow;
    logic signed [15:0]    tin;
    logic [15:0]           d;
    logic [39:0]           tt;
    logic signed [L_W-1:0] lval;
    logic [15:0]           drop;
  } item_t;

endpackage

FILE: sv/hpl_div.sv
// hpl_div.sv: pipelined restoring divider, one quotient bit per stage.
// Depends on hpl_pkg.
module hpl_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [hpl_pkg::DIV_NUM_W-1:0]  num,
  input  logic [hpl_pkg::DIV_DEN_W-1:0]  den,
  input  hpl_pkg::item_t                 in_item,
  output logic                           out_valid,
  output logic [hpl_pkg::DIV_NUM_W-1:0]  quo,
  output hpl_pkg::item_t                 out_item
);
  import hpl_pkg::*;

  typedef struct packed {
    logic [DIV_NUM_W-1:0] acc;
    logic [DIV_DEN_W-1:0] rem;
    logic [DIV_DEN_W-1:0] den;
    item_t                item;
  } div_t;

  logic vld [DIV_NUM_W];
  div_t st  [DIV_NUM_W];

  for (genvar i = 0; i < DIV_NUM_W; i++) begin : g_step
    div_t src;
    div_t nxt;
    logic src_v;
    if (i == 0) begin : g_head
      assign src_v = in_valid;
      assign src   = '{acc: num, rem: '0, den: den, item: in_item};
    end else begin : g_link
      assign src_v = vld[i-1];
      assign src   = st[i-1];
    end
    always_comb begin
      logic [DIV_DEN_W:0] t;
      logic               ge;
      t       = {src.rem, src.acc[DIV_NUM_W-1]};
      ge      = t >= {1'b0, src.den};
      nxt     = src;
      nxt.acc = {src.acc[DIV_NUM_W-2:0], ge};
      nxt.rem = ge ? DIV_DEN_W'(t - {1'b0, src.den}) : t[DIV_DEN_W-1:0];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= src_v;
      end
      if (en) begin
        st[i] <= nxt;
      end
    end
  end

  assign out_valid = vld[DIV_NUM_W-1];
  assign quo       = st[DIV_NUM_W-1].acc;
  assign out_item  = st[DIV_NUM_W-1].item;

endmodule

FILE: sv/hpl_lg2.sv
// hpl_lg2.sv: pipelined base-2 logarithm over four lanes, Q32 result.
// Depends on hpl_pkg.
module hpl_lg2 (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [hpl_pkg::LG_IN_W-1:0]  x [hpl_pkg::LG_LANES],
  input  hpl_pkg::item_t               in_item,
  output logic                         out_valid,
  output logic [hpl_pkg::LG_W-1:0]     y [hpl_pkg::LG_LANES],
  output hpl_pkg::item_t               out_item
);
  import hpl_pkg::*;

  localparam int STAGES = LG_NORM + QF;

  typedef struct packed {
    logic [LG_IN_W-1:0] m;
    logic [5:0]         cnt;
    logic [QF-1:0]      frac;
  } lane_t;

  typedef struct packed {
    lane_t [LG_LANES-1:0] ln;
    item_t                item;
  } lg_t;

  logic vld [STAGES];
  lg_t  st  [STAGES];
  lg_t  head;

  always_comb begin
    head.item = in_item;
    for (int j = 0; j < LG_LANES; j++) begin
      head.ln[j].m    = x[j];
      head.ln[j].cnt  = '0;
      head.ln[j].frac = '0;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    lg_t  src;
    lg_t  nxt;
    logic src_v;
    if (i == 0) begin : g_head
      assign src_v = in_valid;
      assign src   = head;
    end else begin : g_link
      assign src_v = vld[i-1];
      assign src   = st[i-1];
    end
    if (i < LG_NORM) begin : g_norm
      localparam int S = (LG_IN_W / 2) >> i;
      always_comb begin
        nxt = src;
        for (int j = 0; j < LG_LANES; j++) begin
          if (src.ln[j].m[LG_IN_W-1 -: S] == '0) begin
            nxt.ln[j].m   = src.ln[j].m << S;
            nxt.ln[j].cnt = src.ln[j].cnt + 6'(S);
          end
        end
      end
    end else begin : g_sq
      always_comb begin
        logic [QF-1:0]   a;
        logic [2*QF-1:0] sq;
        logic [QF:0]     m2;
        nxt = src;
        for (int j = 0; j < LG_LANES; j++) begin
          a  = src.ln[j].m[LG_IN_W-1 -: QF];
          sq = (2*QF)'(a) * (2*QF)'(a);
          m2 = sq[2*QF-1:QF-1];
          nxt.ln[j].m    = {(m2[QF] ? m2[QF:1] : m2[QF-1:0]), {(LG_IN_W-QF){1'b0}}};
          nxt.ln[j].frac = {src.ln[j].frac[QF-2:0], m2[QF]};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= src_v;
      end
      if (en) begin
        st[i] <= nxt;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < LG_LANES; j++) begin
      y[j] = {6'(LG_IN_W - 1) - st[STAGES-1].ln[j].cnt, st[STAGES-1].ln[j].frac};
    end
  end

  assign out_valid = vld[STAGES-1];
  assign out_item  = st[STAGES-1].item;

endmodule

FILE: sv/hpl_exp2.sv
// hpl_exp2.sv: pipelined power of two of a signed Q32 argument, Taylor
// series of the fraction, one term per two stages. Depends on hpl_pkg.
module hpl_exp2 (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [hpl_pkg::EXP_IN_W-1:0] f,
  input  hpl_pkg::item_t                      in_item,
  output logic                                out_valid,
  output logic [hpl_pkg::EXP_OUT_W-1:0]       e,
  output hpl_pkg::item_t                      out_item
);
  import hpl_pkg::*;

  localparam int ST_N = 2 * EXP_TERMS - 1;
  localparam int IP_W = EXP_IN_W - QF;

  typedef struct packed {
    logic [QF-1:0]        z;
    logic [QF-1:0]        term;
    logic [EXP_SUM_W-1:0] sum;
    logic                 left;
    logic                 zero;
    logic [5:0]           amt;
    item_t                item;
  } exp_t;

  logic vld [ST_N];
  exp_t st  [ST_N];
  exp_t head;

  always_comb begin
    logic signed [IP_W-1:0] ip;
    logic signed [IP_W-1:0] neg;
    logic [2*QF-1:0]        zp;
    ip        = f[EXP_IN_W-1:QF];
    neg       = -ip;
    zp        = (2*QF)'(f[QF-1:0]) * (2*QF)'(LN2_Q32);
    head.item = in_item;
    head.z    = zp[2*QF-1:QF];
    head.term = zp[2*QF-1:QF];
    head.sum  = (EXP_SUM_W'(1) << QF) + EXP_SUM_W'(zp[2*QF-1:QF]);
    head.left = !ip[IP_W-1];
    if (!ip[IP_W-1]) begin
      head.zero = 1'b0;
      head.amt  = (ip > IP_W'(EXP_MAX_SHL)) ? 6'(EXP_MAX_SHL) : ip[5:0];
    end else begin
      head.zero = neg >= IP_W'(EXP_MIN_SHR);
      head.amt  = neg[5:0];
    end
  end

  for (genvar i = 0; i < ST_N; i++) begin : g_stage
    exp_t src;
    exp_t nxt;
    logic src_v;
    if (i == 0) begin : g_head
      assign src_v = in_valid;
      assign src   = head;
      assign nxt   = src;
    end else begin : g_term
      localparam int K  = (i + 3) / 2;
      localparam int SH = QF + $clog2(K);
      localparam logic [QF:0] M = (QF+1)'(((65'd1 << SH) + 65'(K) - 65'd1) / 65'(K));
      assign src_v = vld[i-1];
      assign src   = st[i-1];
      if (i % 2 == 1) begin : g_mul
        always_comb begin
          logic [2*QF-1:0] p;
          p        = (2*QF)'(src.term) * (2*QF)'(src.z);
          nxt      = src;
          nxt.term = p[2*QF-1:QF];
        end
      end else begin : g_div
        always_comb begin
          logic [2*QF:0] pm;
          logic [QF-1:0] t;
          pm       = (2*QF+1)'(src.term) * (2*QF+1)'(M);
          t        = QF'(pm >> SH);
          nxt      = src;
          nxt.term = t;
          nxt.sum  = src.sum + EXP_SUM_W'(t);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= src_v;
      end
      if (en) begin
        st[i] <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[ST_N-1];
    end
    if (en) begin
      out_item <= st[ST_N-1].item;
      if (st[ST_N-1].zero) begin
        e <= '0;
      end else if (st[ST_N-1].left) begin
        e <= EXP_OUT_W'(st[ST_N-1].sum) << st[ST_N-1].amt;
      end else begin
        e <= EXP_OUT_W'(st[ST_N-1].sum >> st[ST_N-1].amt);
      end
    end
  end

endmodule

FILE: sv/heating_pipe_heat_loss_unit.sv
// heating_pipe_heat_loss_unit.sv: top level of the heating pipe heat loss
// unit. Depends on hpl_pkg, hpl_div, hpl_lg2 and hpl_exp2.
//
// Input channel in_valid/in_ready carries one beat per evaluation
// (inflow_temp, indoor_temp, flow_rate, flow_unknown); output channel
// out_valid/out_ready returns one result beat per input beat, in order.
// Configuration writes arrive on cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high, writes belong to idle periods.
// The datapath is one stalling pipeline: a beat enters every cycle while
// it is not frozen, and passes through 1 entry stage, three 54-stage
// dividers, two 38-stage log units, two 60-stage exponent units and 8
// glue and output stages. Throughput is one beat per cycle when not stalled.
// When out_ready is low with a result held, the whole pipeline freezes
// and in_ready drops in the same cycle; nothing is lost or repeated.
// Reset clears every valid bit and loads the register defaults.
module heating_pipe_heat_loss_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [15:0]                inflow_temp,
  input  logic signed [15:0]                indoor_temp,
  input  logic [15:0]                       flow_rate,
  input  logic                              flow_unknown,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [15:0]                outflow_temp,
  output logic [15:0]                       temp_drop,
  output logic [39:0]                       transit_time,
  output logic [31:0]                       energy_flux,
  output logic [1:0]                        status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hpl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hpl_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import hpl_pkg::*;

  logic signed [15:0] max_inflow_temp;
  logic [23:0]        heat_coeff;
  logic [13:0]        exponent_b;
  logic [31:0]        span_volume;
  logic [7:0]         span_count;
  logic [19:0]        floor_area;
  logic [12:0]        water_heat_capacity;
  logic [13:0]        craw;
  logic               en;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign craw      = ((exponent_b < B_MIN) ? B_MIN : exponent_b) - B_ONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_inflow_temp     <= RST_MAX_INFLOW;
      heat_coeff          <= RST_HEAT_COEFF;
      exponent_b          <= RST_EXPONENT_B;
      span_volume         <= RST_SPAN_VOL;
      span_count          <= RST_SPAN_CNT;
      floor_area          <= RST_AREA;
      water_heat_capacity <= RST_HEAT_CAP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_INFLOW: max_inflow_temp     <= $signed(cfg_data[15:0]);
        REG_HEAT_COEFF: heat_coeff          <= cfg_data[23:0];
        REG_EXPONENT_B: exponent_b          <= cfg_data[13:0];
        REG_SPAN_VOL:   span_volume         <= cfg_data;
        REG_SPAN_CNT:   span_count          <= cfg_data[7:0];
        REG_AREA:       floor_area          <= cfg_data[19:0];
        REG_HEAT_CAP:   water_heat_capacity <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // entry: flow substitution and clamp
  logic  v0;
  item_t it0;
  item_t it0_next;

  always_comb begin
    logic signed [15:0] tcl;
    logic signed [15:0] tin;
    logic signed [16:0] dd;
    logic [15:0]        fl;
    fl  = flow_unknown ? DEFAULT_FLOW : flow_rate;
    tcl = (inflow_temp < max_inflow_temp) ? inflow_temp : max_inflow_temp;
    tin = (tcl < indoor_temp) ? indoor_temp : tcl;
    dd  = 17'(tin) - 17'(indoor_temp);
    it0_next           = '0;
    it0_next.zero_flow = (fl == 16'd0);
    it0_next.flow      = fl;
    it0_next.tin       = tin;
    it0_next.d         = dd[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
    if (en) begin
      it0 <= it0_next;
    end
  end

  // transit time
  logic                 v1;
  logic [DIV_NUM_W-1:0] q1;
  item_t                it1;
  item_t                it1x;

  hpl_div u_div_tt (
    .clk(clk), .rst(rst), .en(en), .in_valid(v0),
    .num(DIV_NUM_W'({span_volume, 8'b0})), .den(DIV_DEN_W'(it0.flow)),
    .in_item(it0), .out_valid(v1), .quo(q1), .out_item(it1)
  );

  logic [LG_IN_W-1:0] lg1_x [LG_LANES];
  logic [LG_W-1:0]    lg1_y [LG_LANES];
  logic               v3;
  item_t              it3;

  always_comb begin
    it1x      = it1;
    it1x.tt   = q1[39:0];
    it1x.cool = (it1.d != 16'd0) && (heat_coeff != 24'd0) && (q1[39:0] != 40'd0);
    lg1_x[0]  = LG_IN_W'(heat_coeff);
    lg1_x[1]  = LG_IN_W'(craw);
    lg1_x[2]  = LG_IN_W'(q1[39:0]);
    lg1_x[3]  = LG_IN_W'(it1.d);
  end

  hpl_lg2 u_lg_terms (
    .clk(clk), .rst(rst), .en(en), .in_valid(v1), .x(lg1_x), .in_item(it1x),
    .out_valid(v3), .y(lg1_y), .out_item(it3)
  );

  // exponent of the cooling term
  logic               v4;
  item_t              it4;
  logic signed [51:0] prodd;
  logic signed [41:0] psum;
  logic               v5;
  item_t              it5;

  always_ff @(posedge clk) begin
    logic signed [39:0] dlg;
    dlg = $signed(40'(lg1_y[3])) - (40'sd8 <<< QF);
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
      v5 <= v4;
    end
    if (en) begin
      it4   <= it3;
      prodd <= 52'($signed({1'b0, craw})) * 52'(dlg);
      psum  <= $signed(42'(lg1_y[0]) + 42'(lg1_y[1]) + 42'(lg1_y[2])) - (42'sd44 <<< QF);
    end
  end

  always_ff @(posedge clk) begin
    logic signed [51:0]    qd;
    logic signed [L_W-1:0] lv;
    item_t                 it5_next;
    qd = (prodd < 0) ? ((prodd + 52'sd4095) >>> 12) : (prodd >>> 12);
    lv = L_W'(psum + 42'(qd));
    it5_next      = it4;
    it5_next.lval = lv;
    it5_next.big  = lv >= (40'sd30 <<< QF);
    it5_next.tiny = lv < -(40'sd40 <<< QF);
    if (en) begin
      it5 <= it5_next;
    end
  end

  logic                 v6;
  logic [EXP_OUT_W-1:0] e1;
  item_t                it6;

  hpl_exp2 u_exp_u (
    .clk(clk), .rst(rst), .en(en), .in_valid(v5),
    .f(EXP_IN_W'($signed(it5.lval))), .in_item(it5),
    .out_valid(v6), .e(e1), .out_item(it6)
  );

  logic [LG_IN_W-1:0] lg2_x [LG_LANES];
  logic [LG_W-1:0]    lg2_y [LG_LANES];
  logic               v7;
  item_t              it7;

  always_comb begin
    for (int j = 0; j < LG_LANES; j++) begin
      lg2_x[j] = '0;
    end
    lg2_x[0] = LG_IN_W'(e1) + (LG_IN_W'(1) << QF);
  end

  hpl_lg2 u_lg_one (
    .clk(clk), .rst(rst), .en(en), .in_valid(v6), .x(lg2_x), .in_item(it6),
    .out_valid(v7), .y(lg2_y), .out_item(it7)
  );

  // s / c and the exit excess factor
  logic                 v8;
  item_t                it8;
  logic [DIV_NUM_W-1:0] num2;

  always_ff @(posedge clk) begin
    logic signed [L_W-1:0] lgv;
    logic signed [L_W-1:0] sv;
    lgv = $signed(L_W'(lg2_y[0])) - (40'sd32 <<< QF);
    if (it7.big) begin
      sv = it7.lval;
    end else if (it7.tiny) begin
      sv = '0;
    end else begin
      sv = lgv;
    end
    if (sv < 0) begin
      sv = '0;
    end
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
    if (en) begin
      it8  <= it7;
      num2 <= DIV_NUM_W'({sv[L_W-2:0], 12'b0});
    end
  end

  logic                 v9;
  logic [DIV_NUM_W-1:0] q2;
  item_t                it9;

  hpl_div u_div_c (
    .clk(clk), .rst(rst), .en(en), .in_valid(v8), .num(num2),
    .den(DIV_DEN_W'(craw)), .in_item(it8), .out_valid(v9), .quo(q2), .out_item(it9)
  );

  logic                 v10;
  logic [EXP_OUT_W-1:0] e2;
  item_t                it10;

  hpl_exp2 u_exp_g (
    .clk(clk), .rst(rst), .en(en), .in_valid(v9),
    .f(-$signed(EXP_IN_W'(q2))), .in_item(it9),
    .out_valid(v10), .e(e2), .out_item(it10)
  );

  // drop and flux numerator
  logic        v11;
  item_t       it11;
  logic [49:0] pr;
  logic        v12;
  item_t       it12;
  logic        v13;
  item_t       it13;
  logic [20:0] m1;
  logic [31:0] m2;
  logic        v14;
  item_t       it14;
  logic [DIV_NUM_W-1:0] num3;
  logic [DIV_DEN_W-1:0] den3;

  always_ff @(posedge clk) begin
    logic [49:0] ys;
    logic [17:0] yv;
    logic [15:0] ym;
    item_t       it12_next;
    ys = pr + (50'd1 << (QF - 1));
    yv = ys[49:QF];
    ym = (yv > 18'(it11.d)) ? it11.d : yv[15:0];
    it12_next      = it11;
    it12_next.drop = it11.cool ? (it11.d - ym) : 16'd0;
    if (rst) begin
      v11 <= 1'b0;
      v12 <= 1'b0;
      v13 <= 1'b0;
      v14 <= 1'b0;
    end else if (en) begin
      v11 <= v10;
      v12 <= v11;
      v13 <= v12;
      v14 <= v13;
    end
    if (en) begin
      it11      <= it10;
      pr        <= 50'(it10.d) * 50'(e2[EXP_SUM_W-1:0]);
      it12      <= it12_next;
      it13      <= it12;
      m1        <= 21'(span_count) * 21'(water_heat_capacity);
      m2        <= 32'(it12.drop) * 32'(it12.flow);
      it14      <= it13;
      num3      <= DIV_NUM_W'(m1) * DIV_NUM_W'(m2);
      den3      <= DIV_DEN_W'(FLUX_SCALE) *
                   DIV_DEN_W'((floor_area == 20'd0) ? 20'd1 : floor_area);
    end
  end

  logic                 v15;
  logic [DIV_NUM_W-1:0] q3;
  item_t                it15;

  hpl_div u_div_flux (
    .clk(clk), .rst(rst), .en(en), .in_valid(v14), .num(num3), .den(den3),
    .in_item(it14), .out_valid(v15), .quo(q3), .out_item(it15)
  );

  // output register
  always_ff @(posedge clk) begin
    logic sat;
    sat = |q3[DIV_NUM_W-1:32];
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v15;
    end
    if (en) begin
      if (it15.zero_flow) begin
        outflow_temp <= '0;
        temp_drop    <= '0;
        transit_time <= '0;
        energy_flux  <= '0;
        status       <= ST_ZERO_FLOW;
      end else begin
        outflow_temp <= it15.tin - $signed(it15.drop);
        temp_drop    <= it15.drop;
        transit_time <= it15.tt;
        energy_flux  <= sat ? 32'hFFFF_FFFF : q3[31:0];
        status       <= sat ? ST_SAT : ST_OK;
      end
    end
  end

endmodule
